// ----- src/rrqs_pkg.sv -----
// Shared constants, types and helpers for the round-robin quantum scheduler.
`default_nettype none
package rrqs_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int TIME_W     = 16;
    localparam int TIDX_W     = $clog2(MAX_TASKS);
    localparam int LOAD_W     = $clog2(MAX_TASKS + 1);
    localparam int BURST_W    = 6;
    localparam int CODE_W     = 4;
    localparam int EVENT_W    = 3;
    localparam int SLICE_W    = 4;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 4'd3;

    localparam logic [EVENT_W-1:0] EV_LOADED      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_FULL        = 3'd1;
    localparam logic [EVENT_W-1:0] EV_RAN         = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SLICE_END   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FINISHED    = 3'd4;
    localparam logic [EVENT_W-1:0] EV_INTERRUPTED = 3'd5;
    localparam logic [EVENT_W-1:0] EV_IDLE        = 3'd6;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] elapsed;
        logic [BURST_W-1:0] ipoint;
        logic [CODE_W-1:0]  code;
    } entry_t;

    typedef struct packed {
        logic cap_in;
        logic do_load;
        logic scan_start;
        logic scan_step;
        logic scan_take;
        logic do_run;
        logic set_idle;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic cur_alive;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [TIDX_W-1:0] next_idx(input logic [TIDX_W-1:0] idx);
        logic [TIDX_W-1:0] res;
        if (idx == TIDX_W'(MAX_TASKS - 1))
            res = '0;
        else
            res = idx + 1'b1;
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- src/rrqs_ctrl.sv -----
// Sequencing state machine of the scheduler.
`default_nettype none
module rrqs_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  rrqs_pkg::dp_status_t status,
    output rrqs_pkg::ctrl_cmd_t  cmd
);
    import rrqs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!status.is_tick)
                begin
                    cmd.do_load = 1'b1;
                    state_next  = S_DONE;
                end
                else if (status.cur_alive)
                    state_next = S_RUN;
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_hit)
                begin
                    cmd.scan_take = 1'b1;
                    state_next    = S_RUN;
                end
                else if (status.scan_last)
                begin
                    cmd.set_idle = 1'b1;
                    state_next   = S_DONE;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_RUN:
            begin
                cmd.do_run = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ----- src/rrqs_dpath.sv -----
// Task table, counters, scan pointer and output register of the scheduler.
`default_nettype none
module rrqs_dpath (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    input  wire  [rrqs_pkg::SLICE_W-1:0]     slice_length,
    input  wire                              command,
    input  wire  [rrqs_pkg::BURST_W-1:0]     burst_cycles,
    input  wire  [rrqs_pkg::BURST_W-1:0]     interrupt_point,
    input  wire  [rrqs_pkg::CODE_W-1:0]      interrupt_code,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [rrqs_pkg::TIDX_W-1:0]      task_number,
    output logic [rrqs_pkg::EVENT_W-1:0]     event_res,
    output logic [rrqs_pkg::CODE_W-1:0]      reported_code,
    output logic [rrqs_pkg::TIME_W-1:0]      total_time,
    input  wire  rrqs_pkg::ctrl_cmd_t        cmd,
    output rrqs_pkg::dp_status_t             status
);
    import rrqs_pkg::*;

    // captured input item
    logic               cmd_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [BURST_W-1:0] ipoint_reg;
    logic [CODE_W-1:0]  icode_reg;

    entry_t             table_reg [MAX_TASKS];
    logic [MAX_TASKS-1:0] alive_reg;
    logic [LOAD_W-1:0]  loaded_reg;
    logic [TIDX_W-1:0]  cur_reg;
    logic [SLICE_W-1:0] slice_used_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [SLICE_W-1:0] slice_len_reg;
    logic [TIDX_W-1:0]  scan_idx_reg;
    logic [TIDX_W-1:0]  scan_cnt_reg;

    // pending result
    logic [TIDX_W-1:0]  res_task_reg;
    logic [EVENT_W-1:0] res_event_reg;
    logic [CODE_W-1:0]  res_code_reg;

    logic               out_valid_reg;
    logic [TIDX_W-1:0]  out_task_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic [TIME_W-1:0]  out_time_reg;

    // run step
    entry_t             cur_entry;
    logic [BURST_W-1:0] rem_new;
    logic [BURST_W-1:0] el_new;
    logic [SLICE_W:0]   slice_new;
    logic [SLICE_W:0]   limit;
    logic               hit_int;
    logic               hit_fin;
    logic               hit_slice;
    logic               table_full;
    logic [TIDX_W-1:0]  load_idx;

    assign cur_entry  = table_reg[cur_reg];
    assign rem_new    = cur_entry.remaining - 1'b1;
    assign el_new     = cur_entry.elapsed + 1'b1;
    assign slice_new  = {1'b0, slice_used_reg} + 1'b1;
    assign limit      = (slice_len_reg == '0) ? (SLICE_W+1)'(1) : {1'b0, slice_len_reg};
    assign hit_int    = (cur_entry.ipoint != '0) && (el_new == cur_entry.ipoint);
    assign hit_fin    = (rem_new == '0);
    assign hit_slice  = (slice_new >= limit);
    assign table_full = (loaded_reg == LOAD_W'(MAX_TASKS));
    assign load_idx   = loaded_reg[TIDX_W-1:0];

    always_comb
    begin
        status.is_tick   = (cmd_reg == CMD_TICK);
        status.cur_alive = alive_reg[cur_reg];
        status.scan_hit  = alive_reg[scan_idx_reg];
        status.scan_last = (scan_cnt_reg == TIDX_W'(MAX_TASKS - 1));
        status.out_free  = !out_valid_reg || out_ready;
    end

    // table payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.do_load && !table_full)
        begin
            table_reg[load_idx].remaining <= burst_reg;
            table_reg[load_idx].elapsed   <= '0;
            table_reg[load_idx].ipoint    <= ipoint_reg;
            table_reg[load_idx].code      <= icode_reg;
        end
        else if (cmd.do_run)
        begin
            table_reg[cur_reg].remaining <= rem_new;
            table_reg[cur_reg].elapsed   <= el_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            cmd_reg    <= command;
            burst_reg  <= burst_cycles;
            ipoint_reg <= interrupt_point;
            icode_reg  <= interrupt_code;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg <= next_idx(cur_reg);
            scan_cnt_reg <= TIDX_W'(1);
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= next_idx(scan_idx_reg);
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
        if (cmd.do_load)
        begin
            res_task_reg  <= table_full ? '0 : load_idx;
            res_event_reg <= table_full ? EV_FULL : EV_LOADED;
            res_code_reg  <= '0;
        end
        else if (cmd.set_idle)
        begin
            res_task_reg  <= '0;
            res_event_reg <= EV_IDLE;
            res_code_reg  <= '0;
        end
        else if (cmd.do_run)
        begin
            res_task_reg <= cur_reg;
            res_code_reg <= hit_int ? cur_entry.code : '0;
            if (hit_int)
                res_event_reg <= EV_INTERRUPTED;
            else if (hit_fin)
                res_event_reg <= EV_FINISHED;
            else if (hit_slice)
                res_event_reg <= EV_SLICE_END;
            else
                res_event_reg <= EV_RAN;
        end
        if (cmd.out_load)
        begin
            out_task_reg  <= res_task_reg;
            out_event_reg <= res_event_reg;
            out_code_reg  <= res_code_reg;
            out_time_reg  <= time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg      <= '0;
            loaded_reg     <= '0;
            cur_reg        <= '0;
            slice_used_reg <= '0;
            time_reg       <= '0;
            slice_len_reg  <= SLICE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                slice_len_reg <= slice_length;
            if (cmd.do_load && !table_full)
            begin
                alive_reg[load_idx] <= (burst_reg != '0);
                loaded_reg          <= loaded_reg + 1'b1;
            end
            if (cmd.scan_take)
            begin
                cur_reg        <= scan_idx_reg;
                slice_used_reg <= '0;
            end
            else if (cmd.do_run)
            begin
                if (time_reg != '1)
                    time_reg <= time_reg + 1'b1;
                if (hit_int || hit_fin)
                    alive_reg[cur_reg] <= 1'b0;
                if (hit_int || hit_fin || hit_slice)
                begin
                    cur_reg        <= next_idx(cur_reg);
                    slice_used_reg <= '0;
                end
                else
                    slice_used_reg <= slice_new[SLICE_W-1:0];
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign task_number   = out_task_reg;
    assign event_res     = out_event_reg;
    assign reported_code = out_code_reg;
    assign total_time    = out_time_reg;

endmodule
`default_nettype wire

// ----- src/round_robin_quantum_scheduler.sv -----
// Top level of the round-robin quantum scheduler: controller plus datapath.
//
// Input channel (in_valid/in_ready): command 0 loads a task (burst_cycles,
// interrupt_point, interrupt_code) into the next table slot, command 1 runs
// one tick. Every accepted item gives exactly one result on the output
// channel (out_valid/out_ready): task_number, event_res, reported_code and
// the saturating total_time after the item.
// Config channel (cfg_valid/cfg_ready): writes slice_length; always ready,
// write only while the block is idle.
// A load passes through the decide and done states. A tick whose current
// task is live passes through decide, run and done; otherwise it first
// searches the table for a live task (one entry per cycle).
// One item is in work at a time; in_ready returns as the result moves to
// the output register, so a new item is not taken until the last one is
// through. A finished result waits in the output register while the
// next item is accepted; a second result waits until out_ready frees it.
// Reset clears the live bits, counters, the turn pointer and the output
// valid, and returns slice_length to 3; task entries need no clearing.
`default_nettype none
module round_robin_quantum_scheduler (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [rrqs_pkg::SLICE_W-1:0]     slice_length,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              command,
    input  wire  [rrqs_pkg::BURST_W-1:0]     burst_cycles,
    input  wire  [rrqs_pkg::BURST_W-1:0]     interrupt_point,
    input  wire  [rrqs_pkg::CODE_W-1:0]      interrupt_code,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [rrqs_pkg::TIDX_W-1:0]      task_number,
    output logic [rrqs_pkg::EVENT_W-1:0]     event_res,
    output logic [rrqs_pkg::CODE_W-1:0]      reported_code,
    output logic [rrqs_pkg::TIME_W-1:0]      total_time
);
    import rrqs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rrqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rrqs_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .slice_length    (slice_length),
        .command         (command),
        .burst_cycles    (burst_cycles),
        .interrupt_point (interrupt_point),
        .interrupt_code  (interrupt_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .task_number     (task_number),
        .event_res       (event_res),
        .reported_code   (reported_code),
        .total_time      (total_time),
        .cmd             (cmd),
        .status          (status)
    );

endmodule
`default_nettype wire
